// ----- rtl/snsched_pkg.sv -----
// ----------------------------------------------------------------------------
// Sensor notification scheduler package
// Codes and control types shared by the scheduler, its channels and checker.
// ----------------------------------------------------------------------------
`default_nettype none

package snsched_pkg;

   localparam int CSR_INDEX_BITS   = 3;
   localparam int MAX_PERIOD_RESET = 60;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_TICK   = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      CAUSE_FIRST    = 2'd0,
      CAUSE_EVENT    = 2'd1,
      CAUSE_DEFERRED = 2'd2,
      CAUSE_MAX      = 2'd3
   } cause_type;

   typedef enum logic [1:0] {
      BAND_LOW    = 2'd0,
      BAND_NORMAL = 2'd1,
      BAND_HIGH   = 2'd2
   } band_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LOWER_LIMIT = 3'd0,
      CSR_UPPER_LIMIT = 3'd1,
      CSR_STEP_SIZE   = 3'd2,
      CSR_MIN_PERIOD  = 3'd3,
      CSR_MAX_PERIOD  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic started;
      logic quiet_over;
      logic pending;
   } flags_type;

   typedef struct packed {
      logic      fire;
      cause_type cause;
   } rpt_type;

endpackage

`default_nettype wire

// ----- rtl/snsched_intf.sv -----
// ----------------------------------------------------------------------------
// Sensor notification scheduler channels
// Valid/ready channels for requests, reports and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface snsched_req_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic                          op;
   logic signed [SAMPLE_BITS-1:0] sample_value;

   modport source (output valid, output op, output sample_value, input ready);
   modport sink (input valid, input op, input sample_value, output ready);
endinterface

interface snsched_rsp_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] report_value;
   logic [1:0]                    report_cause;

   modport source (output valid, output report_value, output report_cause, input ready);
   modport sink (input valid, input report_value, input report_cause, output ready);
endinterface

interface snsched_csr_if
   import snsched_pkg::*;
#(parameter int DATA_BITS = 16);
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [DATA_BITS-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/sensor_notification_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// Sensor notification scheduler
// Decides when a sensor sample is reported from limits, step and periods.
// ----------------------------------------------------------------------------
// Each request is a sample or one timer tick. The block takes one request per
// clock cycle unless a report stalls in the report register. A request is held
// in an input register, and once the report register is free or draining its
// decision is made and, if it fires, written to the report register. The rate
// is set by the state update between those two registers. While a report waits
// in the report register, one more request can enter the input register. The
// request after that waits until the report is taken. Register writes are
// always accepted and must be made while no request is in flight.
`default_nettype none

module sensor_notification_scheduler_unit
   import snsched_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int TICK_BITS   = 16
) (
   input wire logic     clock,
   input wire logic     reset,
   snsched_req_if.sink  req,
   snsched_rsp_if.source rsp,
   snsched_csr_if.sink  csr
);

   localparam int WIN_BITS = SAMPLE_BITS + 2;

   logic signed [SAMPLE_BITS-1:0] lower_limit_ff;
   logic signed [SAMPLE_BITS-1:0] upper_limit_ff;
   logic        [SAMPLE_BITS-1:0] step_size_ff;
   logic        [TICK_BITS-1:0]   min_period_ff;
   logic        [TICK_BITS-1:0]   max_period_ff;

   logic                          in_valid_ff;
   logic                          in_op_ff;
   logic signed [SAMPLE_BITS-1:0] in_sample_ff;

   flags_type                     flags_ff;
   flags_type                     flags_in;
   logic signed [SAMPLE_BITS-1:0] latest_ff;
   logic signed [SAMPLE_BITS-1:0] latest_in;
   band_type                      band_ff;
   band_type                      band_in;
   logic signed [WIN_BITS-1:0]    win_high_ff;
   logic signed [WIN_BITS-1:0]    win_high_in;
   logic signed [WIN_BITS-1:0]    win_low_ff;
   logic signed [WIN_BITS-1:0]    win_low_in;
   logic        [TICK_BITS-1:0]   quiet_ticks_ff;
   logic        [TICK_BITS-1:0]   quiet_ticks_in;
   logic        [TICK_BITS-1:0]   interval_ticks_ff;
   logic        [TICK_BITS-1:0]   interval_ticks_in;

   rpt_type                       rpt;
   logic signed [SAMPLE_BITS-1:0] report_value_in;
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_value_ff;
   cause_type                     rsp_cause_ff;

   logic                          advance;

   // The held request is decided once the report register is free or draining.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign csr.ready = 1'b1;

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.report_value = rsp_value_ff;
   assign rsp.report_cause = rsp_cause_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_limit_ff <= '0;
         upper_limit_ff <= '0;
         step_size_ff   <= SAMPLE_BITS'(1);
         min_period_ff  <= TICK_BITS'(1);
         max_period_ff  <= TICK_BITS'(MAX_PERIOD_RESET);
      end else if (csr.valid && csr.ready) begin
         unique case (csr.index)
            CSR_LOWER_LIMIT: lower_limit_ff <= csr.data[SAMPLE_BITS-1:0];
            CSR_UPPER_LIMIT: upper_limit_ff <= csr.data[SAMPLE_BITS-1:0];
            CSR_STEP_SIZE:   step_size_ff   <= csr.data[SAMPLE_BITS-1:0];
            CSR_MIN_PERIOD:  min_period_ff  <= csr.data[TICK_BITS-1:0];
            CSR_MAX_PERIOD:  max_period_ff  <= csr.data[TICK_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_op_ff     <= req.op;
         in_sample_ff <= req.sample_value;
      end
   end

   snsched_eval #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .TICK_BITS   (TICK_BITS)
   ) u_eval (
      .op                  (in_op_ff),
      .sample_value        (in_sample_ff),
      .lower_limit         (lower_limit_ff),
      .upper_limit         (upper_limit_ff),
      .step_size           (step_size_ff),
      .min_period          (min_period_ff),
      .max_period          (max_period_ff),
      .flags               (flags_ff),
      .latest              (latest_ff),
      .band                (band_ff),
      .win_high            (win_high_ff),
      .win_low             (win_low_ff),
      .quiet_ticks         (quiet_ticks_ff),
      .interval_ticks      (interval_ticks_ff),
      .flags_next          (flags_in),
      .latest_next         (latest_in),
      .band_next           (band_in),
      .win_high_next       (win_high_in),
      .win_low_next        (win_low_in),
      .quiet_ticks_next    (quiet_ticks_in),
      .interval_ticks_next (interval_ticks_in),
      .rpt                 (rpt),
      .report_value        (report_value_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff          <= '0;
         latest_ff         <= '0;
         band_ff           <= BAND_LOW;
         win_high_ff       <= '0;
         win_low_ff        <= '0;
         quiet_ticks_ff    <= '0;
         interval_ticks_ff <= '0;
      end else if (advance) begin
         flags_ff          <= flags_in;
         latest_ff         <= latest_in;
         band_ff           <= band_in;
         win_high_ff       <= win_high_in;
         win_low_ff        <= win_low_in;
         quiet_ticks_ff    <= quiet_ticks_in;
         interval_ticks_ff <= interval_ticks_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rpt.fire;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && rpt.fire) begin
         rsp_value_ff <= report_value_in;
         rsp_cause_ff <= rpt.cause;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/snsched_eval.sv -----
// ----------------------------------------------------------------------------
// Sensor notification scheduler decision logic
// Works out the report decision and the next scheduler state for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module snsched_eval
   import snsched_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int TICK_BITS   = 16
) (
   input  wire logic                            op,
   input  wire logic signed [SAMPLE_BITS-1:0]   sample_value,
   input  wire logic signed [SAMPLE_BITS-1:0]   lower_limit,
   input  wire logic signed [SAMPLE_BITS-1:0]   upper_limit,
   input  wire logic        [SAMPLE_BITS-1:0]   step_size,
   input  wire logic        [TICK_BITS-1:0]     min_period,
   input  wire logic        [TICK_BITS-1:0]     max_period,
   input  wire flags_type                       flags,
   input  wire logic signed [SAMPLE_BITS-1:0]   latest,
   input  wire band_type                        band,
   input  wire logic signed [SAMPLE_BITS+1:0]   win_high,
   input  wire logic signed [SAMPLE_BITS+1:0]   win_low,
   input  wire logic        [TICK_BITS-1:0]     quiet_ticks,
   input  wire logic        [TICK_BITS-1:0]     interval_ticks,
   output flags_type                            flags_next,
   output logic signed [SAMPLE_BITS-1:0]        latest_next,
   output band_type                             band_next,
   output logic signed [SAMPLE_BITS+1:0]        win_high_next,
   output logic signed [SAMPLE_BITS+1:0]        win_low_next,
   output logic        [TICK_BITS-1:0]          quiet_ticks_next,
   output logic        [TICK_BITS-1:0]          interval_ticks_next,
   output rpt_type                              rpt,
   output logic signed [SAMPLE_BITS-1:0]        report_value
);

   localparam int WIN_BITS = SAMPLE_BITS + 2;

   function automatic band_type band_of(input logic signed [SAMPLE_BITS-1:0] s,
                                        input logic signed [SAMPLE_BITS-1:0] lo,
                                        input logic signed [SAMPLE_BITS-1:0] hi);
      band_type b;
      if (s > hi) begin
         b = BAND_HIGH;
      end else if (s <= lo) begin
         b = BAND_LOW;
      end else begin
         b = BAND_NORMAL;
      end
      return b;
   endfunction

   logic signed [WIN_BITS-1:0] sample_ext;
   logic signed [WIN_BITS-1:0] report_ext;
   logic signed [WIN_BITS-1:0] step_ext;
   logic                       reportable;
   logic [TICK_BITS-1:0]       quiet_inc;
   logic [TICK_BITS-1:0]       interval_inc;

   assign sample_ext   = WIN_BITS'(sample_value);
   assign report_ext   = WIN_BITS'(report_value);
   assign step_ext     = $signed({2'b00, step_size});
   assign reportable   = (band_of(sample_value, lower_limit, upper_limit) != band) ||
                         (sample_ext >= win_high) || (sample_ext <= win_low);
   assign quiet_inc    = (quiet_ticks == '1) ? quiet_ticks : quiet_ticks + 1'b1;
   assign interval_inc = (interval_ticks == '1) ? interval_ticks : interval_ticks + 1'b1;

   always_comb begin
      flags_next          = flags;
      latest_next         = latest;
      band_next           = band;
      win_high_next       = win_high;
      win_low_next        = win_low;
      quiet_ticks_next    = quiet_ticks;
      interval_ticks_next = interval_ticks;
      rpt.fire            = 1'b0;
      rpt.cause           = CAUSE_FIRST;
      report_value        = latest;

      unique case (op_type'(op))
         OP_SAMPLE: begin
            latest_next  = sample_value;
            report_value = sample_value;
            if (!flags.started) begin
               flags_next.started = 1'b1;
               rpt.fire           = 1'b1;
               rpt.cause          = CAUSE_FIRST;
            end else if (reportable) begin
               if (flags.quiet_over) begin
                  rpt.fire  = 1'b1;
                  rpt.cause = CAUSE_EVENT;
               end else begin
                  flags_next.pending = 1'b1;
               end
            end
         end
         OP_TICK: begin
            if (flags.started) begin
               interval_ticks_next = interval_inc;
               if (!flags.quiet_over) begin
                  quiet_ticks_next = quiet_inc;
                  if (quiet_inc >= min_period) begin
                     if (flags.pending) begin
                        rpt.fire  = 1'b1;
                        rpt.cause = CAUSE_DEFERRED;
                     end else begin
                        flags_next.quiet_over = 1'b1;
                     end
                  end
               end
               if (!rpt.fire && interval_inc >= max_period) begin
                  rpt.fire  = 1'b1;
                  rpt.cause = CAUSE_MAX;
               end
            end
         end
         default: begin
         end
      endcase

      // Every report recenters the step window and restarts both counters.
      if (rpt.fire) begin
         band_next             = band_of(report_value, lower_limit, upper_limit);
         win_high_next         = report_ext + step_ext;
         win_low_next          = report_ext - step_ext;
         flags_next.quiet_over = 1'b0;
         flags_next.pending    = 1'b0;
         quiet_ticks_next      = '0;
         interval_ticks_next   = '0;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/snsched_chk.sv -----
// ----------------------------------------------------------------------------
// Sensor notification scheduler checker
// Port-level checks of report ordering and report channel behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module snsched_chk
   import snsched_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic [SAMPLE_BITS-1:0] rsp_report_value,
   input wire logic [1:0]             rsp_report_cause
);

   logic seen_req_ff;
   logic seen_rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_req_ff <= 1'b0;
         seen_rsp_ff <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            seen_req_ff <= 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            seen_rsp_ff <= 1'b1;
         end
      end
   end

   // A stalled report keeps its value and cause.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_report_value) &&
                                  $stable(rsp_report_cause))
      else $error("stalled report changed");

   // No report can appear before any request was accepted.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> seen_req_ff)
      else $error("report without a request");

   // The first report after reset is the first-sample report.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !seen_rsp_ff |-> rsp_report_cause == CAUSE_FIRST)
      else $error("first report has wrong cause");

   // The first-sample cause is never seen again once a report was delivered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_rsp_ff |-> rsp_report_cause != CAUSE_FIRST)
      else $error("repeated first-sample report");

endmodule

bind sensor_notification_scheduler_unit snsched_chk #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_snsched_chk (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_report_value (rsp.report_value),
   .rsp_report_cause (rsp.report_cause)
);

`default_nettype wire
